>>> design/stm_pkg.sv
// ---------------------------------------------------------------------------
// stm_pkg
// Shared sizes, word types and cell link types for the sliding trimmed mean.
// ---------------------------------------------------------------------------
package stm_pkg;

    localparam int WINDOW  = 30;
    localparam int COORD_W = 12;
    localparam int KEEP_W  = 5;
    localparam int IDX_W   = $clog2(WINDOW);
    localparam int SUM_W   = $clog2(WINDOW * ((1 << COORD_W) - 1) + 1);
    localparam int DCNT_W  = $clog2(SUM_W + 1);

    localparam logic [KEEP_W-1:0] KEEP_RESET = KEEP_W'(6);

    typedef struct packed {
        logic [COORD_W-1:0] x_position;
        logic [COORD_W-1:0] y_position;
    } t_in_word;

    typedef struct packed {
        logic [COORD_W-1:0] x_filtered;
        logic [COORD_W-1:0] y_filtered;
    } t_out_word;

    // What one cell shows to its neighbours.
    typedef struct packed {
        logic [COORD_W-1:0] value;
        logic [IDX_W-1:0]   slot;
        logic               gt;     // value above the incoming sample
        logic               dpre;   // the retiring entry sits here or further left
    } t_link;

    // Update command broadcast along the chain.
    typedef struct packed {
        logic               load;
        logic               prime;
        logic [COORD_W-1:0] new_value;
        logic [IDX_W-1:0]   wr_slot;
    } t_cell_ctrl;

endpackage

>>> design/stm_cell.sv
// ---------------------------------------------------------------------------
// stm_cell
// One place of the sorted window: holds a sample and its ring slot, and on
// each update takes its value from itself, a neighbour or the new sample.
// ---------------------------------------------------------------------------
module stm_cell (
    input  logic                     i_clk,
    input  stm_pkg::t_cell_ctrl      i_ctrl,
    input  logic [stm_pkg::IDX_W-1:0] i_slot_init,
    input  stm_pkg::t_link           i_left,
    input  stm_pkg::t_link           i_right,
    output stm_pkg::t_link           o_self
);

    logic [stm_pkg::COORD_W-1:0] r_value;
    logic [stm_pkg::IDX_W-1:0]   r_slot;
    logic [stm_pkg::COORD_W-1:0] n_value;
    logic [stm_pkg::IDX_W-1:0]   n_slot;
    stm_pkg::t_link              w_cur;
    stm_pkg::t_link              w_prev;

    always_comb begin
        o_self.value = r_value;
        o_self.slot  = r_slot;
        o_self.gt    = (r_value > i_ctrl.new_value);
        o_self.dpre  = i_left.dpre | (r_slot == i_ctrl.wr_slot);
    end

    // Entries of the list once the retiring sample is taken out: the one at
    // this place and the one just left of it.
    always_comb begin
        w_cur  = o_self.dpre ? i_right : o_self;
        w_prev = i_left.dpre ? o_self : i_left;
        if (!w_cur.gt) begin
            n_value = w_cur.value;
            n_slot  = w_cur.slot;
        end else if (!w_prev.gt) begin
            n_value = i_ctrl.new_value;
            n_slot  = i_ctrl.wr_slot;
        end else begin
            n_value = w_prev.value;
            n_slot  = w_prev.slot;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.load) begin
            if (i_ctrl.prime) begin
                r_value <= i_ctrl.new_value;
                r_slot  <= i_slot_init;
            end else begin
                r_value <= n_value;
                r_slot  <= n_slot;
            end
        end
    end

endmodule

>>> design/stm_chain.sv
// ---------------------------------------------------------------------------
// stm_chain
// Row of cells keeping one coordinate's window in ascending order, with a
// single read port into the sorted row.
// ---------------------------------------------------------------------------
module stm_chain (
    input  logic                       i_clk,
    input  stm_pkg::t_cell_ctrl        i_ctrl,
    input  logic [stm_pkg::IDX_W-1:0]  i_rd_idx,
    output logic [stm_pkg::COORD_W-1:0] o_rd_value
);

    stm_pkg::t_link w_self [stm_pkg::WINDOW];
    stm_pkg::t_link w_left_end;
    stm_pkg::t_link w_right_end;

    // The ends behave as minus and plus infinity.
    always_comb begin
        w_left_end       = '0;
        w_right_end      = '0;
        w_right_end.gt   = 1'b1;
        w_right_end.dpre = 1'b1;
    end

    for (genvar g = 0; g < stm_pkg::WINDOW; g++) begin : g_cell
        stm_pkg::t_link w_l;
        stm_pkg::t_link w_r;

        if (g == 0) begin : g_first
            assign w_l = w_left_end;
        end else begin : g_mid_l
            assign w_l = w_self[g-1];
        end

        if (g == stm_pkg::WINDOW - 1) begin : g_last
            assign w_r = w_right_end;
        end else begin : g_mid_r
            assign w_r = w_self[g+1];
        end

        stm_cell u_cell (
            .i_clk       (i_clk),
            .i_ctrl      (i_ctrl),
            .i_slot_init (stm_pkg::IDX_W'(g)),
            .i_left      (w_l),
            .i_right     (w_r),
            .o_self      (w_self[g])
        );
    end

    assign o_rd_value = w_self[i_rd_idx].value;

endmodule

>>> design/stm_div.sv
// ---------------------------------------------------------------------------
// stm_div
// Restoring divider, one quotient bit per cycle; the quotient holds after
// the done pulse until the next start.
// ---------------------------------------------------------------------------
module stm_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [stm_pkg::SUM_W-1:0]   i_dividend,
    input  logic [stm_pkg::KEEP_W-1:0]  i_divisor,
    output logic [stm_pkg::COORD_W-1:0] o_quot,
    output logic                        o_done
);

    logic                        r_busy;
    logic                        r_done;
    logic [stm_pkg::DCNT_W-1:0]  r_cnt;
    logic [stm_pkg::KEEP_W-1:0]  r_rem;
    logic [stm_pkg::KEEP_W-1:0]  r_dsr;
    logic [stm_pkg::SUM_W-1:0]   r_quo;
    logic [stm_pkg::KEEP_W:0]    w_rem_sh;
    logic [stm_pkg::KEEP_W:0]    w_diff;
    logic                        w_ge;

    always_comb begin
        w_rem_sh = {r_rem, r_quo[stm_pkg::SUM_W-1]};
        w_ge     = (w_rem_sh >= {1'b0, r_dsr});
        w_diff   = w_rem_sh - {1'b0, r_dsr};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && (r_cnt == stm_pkg::DCNT_W'(1))) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_cnt <= stm_pkg::DCNT_W'(stm_pkg::SUM_W);
            r_rem <= '0;
            r_dsr <= i_divisor;
            r_quo <= i_dividend;
        end else if (r_busy) begin
            r_cnt <= r_cnt - stm_pkg::DCNT_W'(1);
            r_rem <= w_ge ? w_diff[stm_pkg::KEEP_W-1:0] : w_rem_sh[stm_pkg::KEEP_W-1:0];
            r_quo <= {r_quo[stm_pkg::SUM_W-2:0], w_ge};
        end
    end

    assign o_quot = r_quo[stm_pkg::COORD_W-1:0];
    assign o_done = r_done;

endmodule

>>> design/sliding_trimmed_mean_xy.sv
// ---------------------------------------------------------------------------
// sliding_trimmed_mean_xy
// Sliding trimmed mean of tracked (x, y) positions over a ring window.
// ---------------------------------------------------------------------------
//  Channel  Direction  Handshake              Word
//  in       input      i_in_valid/o_in_stall  t_in_word  (x_position, y_position)
//  out      output     o_out_valid/i_out_stall t_out_word (x_filtered, y_filtered)
//  cfg      input      i_cfg_valid/o_cfg_ready keep_count, 5 bits
//
// A word's sum is built by walking the kept cells one a cycle, keep being
// the clamped keep_count, and the bit-serial dividers then work through the
// sum one dividend bit at a time; once the quotients are in the output
// register the block returns to idle and can take the next word. One word
// is in work at a time.
// Reset clears the control state only; the first word loads every cell.
// A stalled result waits in the output register while the next word is taken.
// ---------------------------------------------------------------------------
module sliding_trimmed_mean_xy (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  stm_pkg::t_in_word          i_in_data,
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output stm_pkg::t_out_word         o_out_data,
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic [stm_pkg::KEEP_W-1:0] i_cfg_data
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_SUM  = 4'b0010,
        S_DIV  = 4'b0100,
        S_HOLD = 4'b1000
    } t_state;

    t_state                       r_state;
    t_state                       n_state;
    logic                         r_primed;
    logic [stm_pkg::IDX_W-1:0]    r_wr_idx;
    logic [stm_pkg::KEEP_W-1:0]   r_keep;
    logic [stm_pkg::KEEP_W-1:0]   r_dsr;
    logic [stm_pkg::IDX_W-1:0]    r_rd_idx;
    logic [stm_pkg::KEEP_W-1:0]   r_cnt;
    logic [stm_pkg::SUM_W-1:0]    r_sum_x;
    logic [stm_pkg::SUM_W-1:0]    r_sum_y;
    logic [stm_pkg::SUM_W-1:0]    n_sum_x;
    logic [stm_pkg::SUM_W-1:0]    n_sum_y;
    logic                         r_out_valid;
    stm_pkg::t_out_word           r_out;

    logic                         w_in_acc;
    logic                         w_out_free;
    logic                         w_load_out;
    logic                         w_div_start;
    logic [stm_pkg::KEEP_W-1:0]   w_keep_eff;
    logic [stm_pkg::IDX_W:0]      w_start_full;
    stm_pkg::t_cell_ctrl          w_ctrl_x;
    stm_pkg::t_cell_ctrl          w_ctrl_y;
    logic [stm_pkg::COORD_W-1:0]  w_rd_x;
    logic [stm_pkg::COORD_W-1:0]  w_rd_y;
    logic [stm_pkg::COORD_W-1:0]  w_quot_x;
    logic [stm_pkg::COORD_W-1:0]  w_quot_y;
    logic                         w_done_x;
    logic                         w_done_y;

    assign w_in_acc    = i_in_valid && (r_state == S_IDLE);
    assign o_in_stall  = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign w_out_free  = !r_out_valid || !i_out_stall;
    assign w_div_start = (r_state == S_SUM) && (r_cnt == stm_pkg::KEEP_W'(1));

    // A zero keep count means one; a count above the window means all of it.
    always_comb begin
        if (r_keep == '0) begin
            w_keep_eff = stm_pkg::KEEP_W'(1);
        end else if (int'(r_keep) > stm_pkg::WINDOW) begin
            w_keep_eff = stm_pkg::KEEP_W'(stm_pkg::WINDOW);
        end else begin
            w_keep_eff = r_keep;
        end
        w_start_full = (stm_pkg::IDX_W+1)'(stm_pkg::WINDOW)
                     - (stm_pkg::IDX_W+1)'(w_keep_eff);
    end

    always_comb begin
        w_ctrl_x.load      = w_in_acc;
        w_ctrl_x.prime     = !r_primed;
        w_ctrl_x.new_value = i_in_data.x_position;
        w_ctrl_x.wr_slot   = r_wr_idx;
        w_ctrl_y           = w_ctrl_x;
        w_ctrl_y.new_value = i_in_data.y_position;
    end

    stm_chain u_chain_x (
        .i_clk      (i_clk),
        .i_ctrl     (w_ctrl_x),
        .i_rd_idx   (r_rd_idx),
        .o_rd_value (w_rd_x)
    );

    stm_chain u_chain_y (
        .i_clk      (i_clk),
        .i_ctrl     (w_ctrl_y),
        .i_rd_idx   (r_rd_idx),
        .o_rd_value (w_rd_y)
    );

    assign n_sum_x = r_sum_x + stm_pkg::SUM_W'(w_rd_x);
    assign n_sum_y = r_sum_y + stm_pkg::SUM_W'(w_rd_y);

    stm_div u_div_x (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (n_sum_x),
        .i_divisor  (r_dsr),
        .o_quot     (w_quot_x),
        .o_done     (w_done_x)
    );

    stm_div u_div_y (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (n_sum_y),
        .i_divisor  (r_dsr),
        .o_quot     (w_quot_y),
        .o_done     (w_done_y)
    );

    always_comb begin
        n_state    = r_state;
        w_load_out = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    n_state = S_SUM;
                end
            end
            S_SUM: begin
                if (w_div_start) begin
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                if (w_done_x && w_done_y) begin
                    if (w_out_free) begin
                        w_load_out = 1'b1;
                        n_state    = S_IDLE;
                    end else begin
                        n_state = S_HOLD;
                    end
                end
            end
            S_HOLD: begin
                if (w_out_free) begin
                    w_load_out = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_primed    <= 1'b0;
            r_wr_idx    <= '0;
            r_keep      <= stm_pkg::KEEP_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid && o_cfg_ready) begin
                r_keep <= i_cfg_data;
            end
            if (w_in_acc) begin
                r_primed <= 1'b1;
                if (int'(r_wr_idx) == stm_pkg::WINDOW - 1) begin
                    r_wr_idx <= '0;
                end else begin
                    r_wr_idx <= r_wr_idx + stm_pkg::IDX_W'(1);
                end
            end
            if (w_load_out) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_dsr    <= w_keep_eff;
            r_cnt    <= w_keep_eff;
            r_rd_idx <= w_start_full[stm_pkg::IDX_W:1];
            r_sum_x  <= '0;
            r_sum_y  <= '0;
        end else if (r_state == S_SUM) begin
            r_cnt    <= r_cnt - stm_pkg::KEEP_W'(1);
            r_rd_idx <= r_rd_idx + stm_pkg::IDX_W'(1);
            r_sum_x  <= n_sum_x;
            r_sum_y  <= n_sum_y;
        end
        if (w_load_out) begin
            r_out.x_filtered <= w_quot_x;
            r_out.y_filtered <= w_quot_y;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

>>> verif/trimmed_mean_checker.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// trimmed_mean_checker
// Watches the position, result and keep-count channels of the sliding
// trimmed mean. It keeps its own copy of both coordinate windows, predicts
// the filtered pair for every accepted position word and compares each
// accepted result word, field by field, with the oldest prediction.
// ---------------------------------------------------------------------------
module trimmed_mean_checker (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    input  logic                       i_in_stall,
    input  stm_pkg::t_in_word          i_in_data,
    input  logic                       i_out_valid,
    input  logic                       i_out_stall,
    input  stm_pkg::t_out_word         i_out_data,
    input  logic                       i_cfg_valid,
    input  logic                       i_cfg_ready,
    input  logic [stm_pkg::KEEP_W-1:0] i_cfg_data,
    output int                         o_fail_count,
    output int                         o_results
);
    import stm_pkg::*;

    logic [WINDOW-1:0][COORD_W-1:0] x_hist;
    logic [WINDOW-1:0][COORD_W-1:0] y_hist;
    logic [IDX_W-1:0]               slot_ptr;
    logic                           seeded;
    logic [KEEP_W-1:0]              keep_now;
    t_out_word                      filtered_due [$];

    // Mean of the middle keep_sel values of the sorted window.
    function automatic logic [COORD_W-1:0] middle_mean(
        input logic [WINDOW-1:0][COORD_W-1:0] hist,
        input logic [KEEP_W-1:0]              keep_sel
    );
        logic [COORD_W-1:0] ordered [WINDOW];
        logic [COORD_W-1:0] v;
        int i;
        int j;
        int n;
        int first;
        int sum;
        for (i = 0; i < WINDOW; i++) ordered[i] = hist[i];
        for (i = 1; i < WINDOW; i++) begin
            v = ordered[i];
            j = i;
            while (j > 0 && ordered[j-1] > v) begin
                ordered[j] = ordered[j-1];
                j--;
            end
            ordered[j] = v;
        end
        // A keep count of zero acts as one; anything above the window averages it all.
        n = int'(keep_sel);
        if (n < 1) n = 1;
        if (n > WINDOW) n = WINDOW;
        first = (WINDOW - n) / 2;
        sum = 0;
        for (i = 0; i < n; i++) sum += int'(ordered[first + i]);
        return COORD_W'(sum / n);
    endfunction

    always @(posedge i_clk) begin
        t_out_word want;
        t_out_word got;
        int i;
        if (!i_rst_n) begin
            x_hist = '0;
            y_hist = '0;
            slot_ptr = '0;
            seeded = 1'b0;
            keep_now = KEEP_RESET;
            filtered_due.delete();
            o_fail_count = 0;
            o_results = 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) keep_now = i_cfg_data;

            // Results are checked before this edge's word is predicted, so the
            // oldest prediction is always the one at the front.
            if (i_out_valid && !i_out_stall) begin
                got = i_out_data;
                o_results++;
                if (filtered_due.size() == 0) begin
                    $error("result word with nothing expected: x %0d y %0d",
                           got.x_filtered, got.y_filtered);
                    o_fail_count++;
                end else begin
                    want = filtered_due.pop_front();
                    if (got.x_filtered !== want.x_filtered) begin
                        $error("x_filtered mismatch: expected %0d, got %0d",
                               want.x_filtered, got.x_filtered);
                        o_fail_count++;
                    end
                    if (got.y_filtered !== want.y_filtered) begin
                        $error("y_filtered mismatch: expected %0d, got %0d",
                               want.y_filtered, got.y_filtered);
                        o_fail_count++;
                    end
                end
            end

            if (i_in_valid && !i_in_stall) begin
                // The first word after reset fills both windows entirely.
                if (!seeded) begin
                    seeded = 1'b1;
                    for (i = 0; i < WINDOW; i++) begin
                        x_hist[i] = i_in_data.x_position;
                        y_hist[i] = i_in_data.y_position;
                    end
                end
                x_hist[slot_ptr] = i_in_data.x_position;
                y_hist[slot_ptr] = i_in_data.y_position;
                slot_ptr = (slot_ptr == IDX_W'(WINDOW - 1)) ? '0 : slot_ptr + IDX_W'(1);
                want.x_filtered = middle_mean(x_hist, keep_now);
                want.y_filtered = middle_mean(y_hist, keep_now);
                filtered_due = {filtered_due, want};
            end
        end
    end

endmodule

>>> verif/tb.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb
// Drives position words into the sliding trimmed mean under a series of keep
// counts, with random gaps on the sender and random stalls on the receiver,
// and leaves the prediction and comparison to the checker beside the block.
// ---------------------------------------------------------------------------
module tb;
    import stm_pkg::*;

    localparam int N_PHASES     = 12;
    localparam int PHASE_WORDS  = 71;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 64;
    localparam int MAX_COORD    = (1 << COORD_W) - 1;

    logic              clk;
    logic              rst_n;
    logic              in_valid;
    logic              in_stall;
    t_in_word          in_word;
    logic              out_valid;
    logic              out_stall;
    t_out_word         out_word;
    logic              cfg_valid;
    logic              cfg_ready;
    logic [KEEP_W-1:0] cfg_keep;
    int                fail_count;
    int                results_seen;
    int                words_sent;
    bit                hold_req;
    bit                steady;
    int                track_x;
    int                track_y;

    sliding_trimmed_mean_xy dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_word),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_word),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_data  (cfg_keep)
    );

    trimmed_mean_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_stall   (in_stall),
        .i_in_data    (in_word),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_out_data   (out_word),
        .i_cfg_valid  (cfg_valid),
        .i_cfg_ready  (cfg_ready),
        .i_cfg_data   (cfg_keep),
        .o_fail_count (fail_count),
        .o_results    (results_seen)
    );

    initial clk = 1'b0;
    always #4 clk = ~clk;

    initial begin
        #6_000_000;
        $display("Some tests failed");
        $finish;
    end

    function automatic int clamp_coord(input int v);
        if (v < 0) return 0;
        if (v > MAX_COORD) return MAX_COORD;
        return v;
    endfunction

    // Phase 0 runs on the reset value; the extremes follow early on.
    function automatic logic [KEEP_W-1:0] keep_for_phase(input int p);
        case (p)
            1:       return KEEP_W'(0);
            2:       return KEEP_W'(1);
            3:       return KEEP_W'(30);
            4:       return KEEP_W'(31);
            5:       return KEEP_W'(29);
            6:       return KEEP_W'(2);
            7:       return KEEP_W'(15);
            8:       return KEEP_W'(7);
            9:       return KEEP_W'(16);
            10:      return KEEP_W'(3);
            default: return KEEP_W'($urandom_range(0, 31));
        endcase
    endfunction

    // Mostly a slowly wandering track with jitter, plus outliers, dropouts
    // to the origin and jumps to the edges of the frame.
    task automatic next_position(output t_in_word w);
        int r;
        r = $urandom_range(0, 99);
        track_x = clamp_coord(track_x + $urandom_range(0, 6) - 3);
        track_y = clamp_coord(track_y + $urandom_range(0, 6) - 3);
        if (r < 70) begin
            w.x_position = COORD_W'(clamp_coord(track_x + $urandom_range(0, 16) - 8));
            w.y_position = COORD_W'(clamp_coord(track_y + $urandom_range(0, 16) - 8));
        end else if (r < 82) begin
            w.x_position = COORD_W'($urandom);
            w.y_position = COORD_W'($urandom);
        end else if (r < 90) begin
            w = '0;
        end else if (r < 95) begin
            w.x_position = $urandom_range(0, 1) ? COORD_W'(MAX_COORD) : '0;
            w.y_position = $urandom_range(0, 1) ? COORD_W'(MAX_COORD) : '0;
        end else begin
            track_x = $urandom_range(0, MAX_COORD);
            track_y = $urandom_range(0, MAX_COORD);
            w.x_position = COORD_W'(track_x);
            w.y_position = COORD_W'(track_y);
        end
    endtask

    task automatic send_word(input t_in_word w);
        int r;
        int gap;
        r = $urandom_range(0, 99);
        gap = 0;
        if (!steady) begin
            if (r >= 92) gap = $urandom_range(8, 40);
            else if (r >= 60) gap = $urandom_range(1, 3);
        end
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_word  <= w;
        do @(posedge clk); while (in_stall);
        words_sent++;
    endtask

    task automatic write_keep(input logic [KEEP_W-1:0] k);
        cfg_valid <= 1'b1;
        cfg_keep  <= k;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    // Receiver: alternating free and stalled runs, and on request one long
    // hold-off so that the block fills up and stalls its input.
    initial begin
        int r;
        int free_len;
        int stall_len;
        out_stall <= 1'b0;
        forever begin
            if (hold_req) begin
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_req = 1'b0;
            end
            out_stall <= 1'b0;
            r = $urandom_range(0, 99);
            free_len = (r < 10) ? $urandom_range(100, 300) : $urandom_range(1, 12);
            repeat (free_len) @(posedge clk);
            r = $urandom_range(0, 99);
            stall_len = 0;
            if (r >= 92) stall_len = $urandom_range(15, 60);
            else if (r >= 55) stall_len = $urandom_range(1, 4);
            if (stall_len > 0) begin
                out_stall <= 1'b1;
                repeat (stall_len) @(posedge clk);
            end
        end
    end

    initial begin
        t_in_word w;
        t_in_word opening [12];
        int p;
        int n;
        rst_n     <= 1'b0;
        in_valid  <= 1'b0;
        in_word   <= '0;
        cfg_valid <= 1'b0;
        cfg_keep  <= '0;
        words_sent = 0;
        hold_req   = 1'b0;
        steady     = 1'b0;
        track_x    = 2048;
        track_y    = 1024;

        // The first word primes the whole window, so it is an extreme one.
        opening[0]  = '{x_position: 12'hFFF, y_position: 12'h000};
        opening[1]  = '{x_position: 12'h000, y_position: 12'hFFF};
        opening[2]  = '{x_position: 12'h000, y_position: 12'h000};
        opening[3]  = '{x_position: 12'hFFF, y_position: 12'hFFF};
        opening[4]  = '{x_position: 12'hAAA, y_position: 12'h555};
        opening[5]  = '{x_position: 12'h555, y_position: 12'hAAA};
        opening[6]  = '{x_position: 12'h001, y_position: 12'hFFE};
        opening[7]  = '{x_position: 12'h800, y_position: 12'h7FF};
        opening[8]  = '{x_position: 12'h000, y_position: 12'h000};
        opening[9]  = '{x_position: 12'h7FF, y_position: 12'h800};
        opening[10] = '{x_position: 12'hFFE, y_position: 12'h001};
        opening[11] = '{x_position: 12'h123, y_position: 12'hEDC};

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (p = 0; p < N_PHASES; p++) begin
            // Every word gives a result, so the block is idle once all are back.
            while (results_seen < words_sent) @(posedge clk);
            if (p > 0) write_keep(keep_for_phase(p));
            steady = ($urandom_range(0, 3) == 0);
            if (p == 2 || p == 8) hold_req = 1'b1;
            if (p == 0) begin
                for (n = 0; n < 12; n++) send_word(opening[n]);
            end
            for (n = 0; n < PHASE_WORDS; n++) begin
                next_position(w);
                send_word(w);
            end
            in_valid <= 1'b0;
        end

        while (results_seen < words_sent) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d position words and checked %0d filtered pairs", words_sent,
                 results_seen);
        $display("across %0d keep counts, from the reset value through 0 and 31", N_PHASES);
        if (fail_count == 0 && results_seen == words_sent) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
